/* rtl/gsw_pkg.sv */
// Package for the graph store and walk core: item types and function codes.
// No dependencies.
`default_nettype none
package gsw_pkg;

  localparam int unsigned VtxW = 6;

  typedef enum logic [2:0] {
    FN_ADD_DIR  = 3'd0,
    FN_ADD_BOTH = 3'd1,
    FN_DEL_DIR  = 3'd2,
    FN_DEL_BOTH = 3'd3,
    FN_QUERY    = 3'd4,
    FN_BFS      = 3'd5,
    FN_DFS      = 3'd6,
    FN_CLEAR    = 3'd7
  } func_e;

  typedef struct packed {
    func_e             func;
    logic [VtxW-1:0]   from_vertex;
    logic [VtxW-1:0]   to_vertex;
  } in_item_t;

  typedef struct packed {
    logic [VtxW-1:0]   visited_vertex;
    logic              edge_present;
    logic              status;
    logic              last;
  } out_item_t;

endpackage
`default_nettype wire

/* rtl/graph_store_bfs_dfs_walk_core.sv */
// Graph store core: adjacency bit matrix in a synchronous RAM, BFS queue and
// DFS stack RAMs, one sequencer. Depends on gsw_pkg.
//
// Edits read the adjacency row and write it back (both rows for the _BOTH
// functions); queries read it; clear goes straight to finish. A BFS fetches
// each queue head, reads its row and enqueues its fresh neighbors; a DFS reads
// the top row, then pushes or pops. The adjacency RAM's single read port sets the pace. One item at a time.
// Reset: no edges (per-row valid bits cleared at once), vertex_count = 64.
`default_nettype none
module graph_store_bfs_dfs_walk_core #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire [6:0]            cfg_wdata_i,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire gsw_pkg::in_item_t in_item_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output gsw_pkg::out_item_t   out_item_o
);

  localparam int unsigned VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  // one-hot sequencer states
  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_EWR1  = 12'b000000000010,
    S_ERD2  = 12'b000000000100,
    S_EWR2  = 12'b000000001000,
    S_FIN   = 12'b000000010000,
    S_BFET  = 12'b000000100000,
    S_BROW  = 12'b000001000000,
    S_BLOAD = 12'b000010000000,
    S_BSCAN = 12'b000100000000,
    S_DRD   = 12'b001000000000,
    S_DCHK  = 12'b010000000000,
    S_DPOP  = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [6:0] vcnt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q <= 7'd64;
    end else if (cfg_we_i) begin
      vcnt_q <= cfg_wdata_i;
    end
  end

  // vertex count in effect and live mask
  logic [6:0]              n_eff;
  logic [MAX_VERTICES-1:0] live_mask;
  always_comb begin
    n_eff = (vcnt_q > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : vcnt_q;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      live_mask[i] = (7'(i) < n_eff);
    end
  end

  // captured item
  gsw_pkg::func_e          func_q;
  logic [VW-1:0]           from_q, to_q;

  // adjacency RAM with per-row valid bits
  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_vld_q;
  logic [MAX_VERTICES-1:0] adj_rd_q;
  logic                    adj_rv_q;
  logic                    adj_re, adj_we;
  logic [VW-1:0]           adj_ra, adj_wa;
  logic [MAX_VERTICES-1:0] adj_wd;
  logic                    clr_rows;

  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      adj_mem[adj_wa] <= adj_wd;
    end
    if (adj_re) begin
      adj_rd_q <= adj_mem[adj_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      adj_rv_q  <= 1'b0;
    end else begin
      if (adj_re) begin
        adj_rv_q <= row_vld_q[adj_ra];
      end
      if (clr_rows) begin
        row_vld_q <= '0;
      end else if (adj_we) begin
        row_vld_q[adj_wa] <= 1'b1;
      end
    end
  end

  logic [MAX_VERTICES-1:0] row_eff;
  assign row_eff = adj_rv_q ? adj_rd_q : '0;

  // shared RAM for the BFS queue and the DFS stack (never live together)
  logic [VW-1:0] ls_mem [MAX_VERTICES];
  logic [VW-1:0] ls_rd_q;
  logic          ls_re, ls_we;
  logic [VW-1:0] ls_ra, ls_wa, ls_wd;

  always_ff @(posedge clk_i) begin
    if (ls_we) begin
      ls_mem[ls_wa] <= ls_wd;
    end
    if (ls_re) begin
      ls_rd_q <= ls_mem[ls_ra];
    end
  end

  // walk state
  logic [MAX_VERTICES-1:0] visited_q, visited_d;
  logic [MAX_VERTICES-1:0] fresh_q, fresh_d;
  logic [VW:0]             head_q, head_d, tail_q, tail_d;
  logic [VW:0]             depth_q, depth_d;
  logic [VW-1:0]           top_q, top_d;

  // pending result, held until we know whether it is the last one
  gsw_pkg::out_item_t      pend_q, pend_d;
  logic                    pend_vld_q, pend_vld_d;

  // output register
  gsw_pkg::out_item_t      out_q, out_d;
  logic                    out_vld_q;
  logic                    emit, oslot;
  assign oslot = !out_vld_q || !out_stall_i;

  // lowest set bit
  function automatic logic [VW-1:0] lowest(input logic [MAX_VERTICES-1:0] b);
    logic [VW-1:0] r;
    r = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (b[i]) r = VW'(i);
    end
    return r;
  endfunction

  logic [MAX_VERTICES-1:0] dfs_fresh;
  logic [VW-1:0]           dfs_w, bfs_w;
  assign dfs_fresh = row_eff & live_mask & ~visited_q;
  assign dfs_w     = lowest(dfs_fresh);
  assign bfs_w     = lowest(fresh_q);

  logic in_acc;
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  logic oor;
  assign oor = ({1'b0, in_item_i.from_vertex} >= n_eff) ||
               ({1'b0, in_item_i.to_vertex} >= n_eff);

  logic                    edit_set;
  logic [MAX_VERTICES-1:0] onehot_t, onehot_f;
  assign edit_set = (func_q == gsw_pkg::FN_ADD_DIR) || (func_q == gsw_pkg::FN_ADD_BOTH);
  assign onehot_t = MAX_VERTICES'(1) << to_q;
  assign onehot_f = MAX_VERTICES'(1) << from_q;

  always_comb begin
    state_d    = state_q;
    visited_d  = visited_q;
    fresh_d    = fresh_q;
    head_d     = head_q;
    tail_d     = tail_q;
    depth_d    = depth_q;
    top_d      = top_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    out_d      = pend_q;
    out_d.last = 1'b0;
    emit       = 1'b0;
    adj_re     = 1'b0;
    adj_ra     = from_q;
    adj_we     = 1'b0;
    adj_wa     = from_q;
    adj_wd     = row_eff;
    clr_rows   = 1'b0;
    ls_re      = 1'b0;
    ls_ra      = head_q[VW-1:0];
    ls_we      = 1'b0;
    ls_wa      = tail_q[VW-1:0];
    ls_wd      = bfs_w;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          pend_d     = '0;
          pend_vld_d = 1'b1;
          if (in_item_i.func == gsw_pkg::FN_CLEAR) begin
            clr_rows = 1'b1;
            state_d  = S_FIN;
          end else if (in_item_i.func == gsw_pkg::FN_BFS ||
                       in_item_i.func == gsw_pkg::FN_DFS) begin
            if (n_eff == 7'd0) begin
              pend_d.status = 1'b1;
              state_d       = S_FIN;
            end else begin
              visited_d = MAX_VERTICES'(1);
              if (in_item_i.func == gsw_pkg::FN_BFS) begin
                pend_vld_d = 1'b0;
                ls_we      = 1'b1;
                ls_wa      = '0;
                ls_wd      = '0;
                head_d     = '0;
                tail_d     = (VW+1)'(1);
                state_d    = S_BFET;
              end else begin
                top_d   = '0;
                depth_d = (VW+1)'(1);
                state_d = S_DRD;
              end
            end
          end else if (oor) begin
            pend_d.status = 1'b1;
            state_d       = S_FIN;
          end else begin
            adj_re  = 1'b1;
            adj_ra  = in_item_i.from_vertex[VW-1:0];
            state_d = S_EWR1;
          end
        end
      end

      S_EWR1: begin
        if (func_q == gsw_pkg::FN_QUERY) begin
          pend_d.edge_present = row_eff[to_q];
          state_d             = S_FIN;
        end else begin
          adj_we  = 1'b1;
          adj_wa  = from_q;
          adj_wd  = edit_set ? (row_eff | onehot_t) : (row_eff & ~onehot_t);
          state_d = (func_q == gsw_pkg::FN_ADD_BOTH || func_q == gsw_pkg::FN_DEL_BOTH)
                    ? S_ERD2 : S_FIN;
        end
      end

      S_ERD2: begin
        adj_re  = 1'b1;
        adj_ra  = to_q;
        state_d = S_EWR2;
      end

      S_EWR2: begin
        adj_we  = 1'b1;
        adj_wa  = to_q;
        adj_wd  = edit_set ? (row_eff | onehot_f) : (row_eff & ~onehot_f);
        state_d = S_FIN;
      end

      S_FIN: begin
        if (oslot) begin
          emit       = 1'b1;
          out_d.last = 1'b1;
          state_d    = S_IDLE;
        end
      end

      // BFS: fetch queue head
      S_BFET: begin
        if (head_q == tail_q) begin
          state_d = S_FIN;
        end else begin
          ls_re   = 1'b1;
          ls_ra   = head_q[VW-1:0];
          state_d = S_BROW;
        end
      end

      S_BROW: begin
        if (!pend_vld_q || oslot) begin
          emit                  = pend_vld_q;
          pend_d                = '0;
          pend_d.visited_vertex = gsw_pkg::VtxW'(ls_rd_q);
          pend_vld_d            = 1'b1;
          head_d                = head_q + 1'b1;
          adj_re                = 1'b1;
          adj_ra                = ls_rd_q;
          state_d               = S_BLOAD;
        end
      end

      S_BLOAD: begin
        fresh_d = row_eff & live_mask & ~visited_q;
        state_d = S_BSCAN;
      end

      // enqueue one fresh neighbor per cycle, ascending
      S_BSCAN: begin
        if (fresh_q == '0) begin
          state_d = S_BFET;
        end else begin
          ls_we            = 1'b1;
          ls_wa            = tail_q[VW-1:0];
          ls_wd            = bfs_w;
          tail_d           = tail_q + 1'b1;
          visited_d[bfs_w] = 1'b1;
          fresh_d[bfs_w]   = 1'b0;
        end
      end

      // DFS: top vertex kept in top_q, frames below it in the stack RAM.
      // Neighbors below the resume point are all visited, so the lowest
      // fresh neighbor is the next one to try.
      S_DRD: begin
        adj_re  = 1'b1;
        adj_ra  = top_q;
        state_d = S_DCHK;
      end

      S_DCHK: begin
        if (dfs_fresh != '0) begin
          if (oslot) begin
            emit                  = 1'b1;
            pend_d                = '0;
            pend_d.visited_vertex = gsw_pkg::VtxW'(dfs_w);
            ls_we                 = 1'b1;
            ls_wa                 = VW'(depth_q - 1'b1);
            ls_wd                 = top_q;
            top_d                 = dfs_w;
            depth_d               = depth_q + 1'b1;
            visited_d[dfs_w]      = 1'b1;
            state_d               = S_DRD;
          end
        end else if (depth_q == (VW+1)'(1)) begin
          depth_d = '0;
          state_d = S_FIN;
        end else begin
          ls_re   = 1'b1;
          ls_ra   = VW'(depth_q - (VW+1)'(2));
          depth_d = depth_q - 1'b1;
          state_d = S_DPOP;
        end
      end

      S_DPOP: begin
        top_d   = ls_rd_q;
        state_d = S_DRD;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      out_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
      head_q     <= '0;
      tail_q     <= '0;
      depth_q    <= '0;
      visited_q  <= '0;
    end else begin
      state_q    <= state_d;
      pend_vld_q <= pend_vld_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      depth_q    <= depth_d;
      visited_q  <= visited_d;
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fresh_q <= fresh_d;
    top_q   <= top_d;
    pend_q  <= pend_d;
    if (emit) begin
      out_q <= out_d;
    end
    if (in_acc) begin
      func_q <= in_item_i.func;
      from_q <= in_item_i.from_vertex[VW-1:0];
      to_q   <= in_item_i.to_vertex[VW-1:0];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  // never overwrite a result that is still waiting
  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> oslot) else $error("result overwritten");

  a_queue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q <= tail_q) && (tail_q <= (VW+1)'(MAX_VERTICES)))
    else $error("queue pointers out of order");

  a_stack_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= (VW+1)'(MAX_VERTICES)) else $error("stack overflow");

  a_root_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRD || state_q == S_BFET) |-> visited_q[0])
    else $error("walk root not marked");

endmodule
`default_nettype wire

/* bench/graph_store_bfs_dfs_walk_core_tb.sv */
// Testbench for graph_store_bfs_dfs_walk_core: edge edits, queries and BFS/DFS walks
// checked item by item against an in-bench graph predictor. Depends on gsw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module graph_store_bfs_dfs_walk_core_tb;

  // Scoreboard: keeps its own copy of the graph and vertex count, expands each
  // accepted item into the walk or edit results the core should return.
  class walk_scoreboard;
    logic [63:0] adj [64];
    int unsigned vcount;
    gsw_pkg::out_item_t pending [$];
    int          errors;

    function void clear_graph();
      for (int i = 0; i < 64; i++) adj[i] = '0;
    endfunction

    function void add_expected(int unsigned v, bit e, bit s, bit l);
      gsw_pkg::out_item_t r;
      r.visited_vertex = v[5:0];
      r.edge_present   = e;
      r.status         = s;
      r.last           = l;
      pending.insert(pending.size(), r);
    endfunction

    function void set_count(logic [6:0] c);
      vcount = c;
    endfunction

    // Expand one accepted input item into expected results.
    function void note_item(gsw_pkg::in_item_t it);
      int unsigned n, f, t, cnt, head, tail, depth, top, v, k, w;
      logic [63:0] mask, seen, fresh;
      int unsigned order [64];
      int unsigned stk_v [64];
      int unsigned stk_k [64];
      n = (vcount > 64) ? 64 : vcount;
      mask = (n >= 64) ? '1 : ((64'd1 << n) - 1);
      f = it.from_vertex;
      t = it.to_vertex;
      if (it.func == gsw_pkg::FN_CLEAR) begin
        clear_graph();
        add_expected(0, 0, 0, 1);
        return;
      end
      if (it.func inside {gsw_pkg::FN_ADD_DIR, gsw_pkg::FN_ADD_BOTH, gsw_pkg::FN_DEL_DIR,
                          gsw_pkg::FN_DEL_BOTH, gsw_pkg::FN_QUERY}) begin
        if (f >= n || t >= n) begin
          add_expected(0, 0, 1, 1);
          return;
        end
        case (it.func)
          gsw_pkg::FN_ADD_DIR: adj[f][t] = 1'b1;
          gsw_pkg::FN_ADD_BOTH: begin
            adj[f][t] = 1'b1;
            adj[t][f] = 1'b1;
          end
          gsw_pkg::FN_DEL_DIR: adj[f][t] = 1'b0;
          gsw_pkg::FN_DEL_BOTH: begin
            adj[f][t] = 1'b0;
            adj[t][f] = 1'b0;
          end
          default: begin
            add_expected(0, adj[f][t], 0, 1);
            return;
          end
        endcase
        add_expected(0, 0, 0, 1);
        return;
      end
      if (n == 0) begin
        add_expected(0, 0, 1, 1);
        return;
      end
      seen = 64'd1;
      cnt = 0;
      if (it.func == gsw_pkg::FN_BFS) begin
        order[0] = 0;
        head = 0;
        tail = 1;
        while (head < tail) begin
          v = order[head];
          head++;
          add_expected(v, 0, 0, 0);
          cnt++;
          fresh = adj[v] & mask & ~seen;
          for (w = 0; w < 64; w++) begin
            if (fresh[w]) begin
              seen[w] = 1'b1;
              order[tail] = w;
              tail++;
            end
          end
        end
      end else begin
        // depth-first preorder, neighbors in ascending order
        stk_v[0] = 0;
        stk_k[0] = 0;
        depth = 1;
        add_expected(0, 0, 0, 0);
        cnt = 1;
        while (depth > 0) begin
          top = depth - 1;
          v = stk_v[top];
          k = stk_k[top];
          fresh = adj[v] & mask & ~seen;
          w = 64;
          for (int i = 63; i >= 0; i--) if (i >= k && fresh[i]) w = i;
          if (w < 64 && depth < 64 && cnt < 64) begin
            stk_k[top] = w + 1;
            seen[w] = 1'b1;
            add_expected(w, 0, 0, 0);
            cnt++;
            stk_v[depth] = w;
            stk_k[depth] = 0;
            depth++;
          end else begin
            depth--;
          end
        end
      end
      pending[$].last = 1'b1;
    endfunction

    function void check_result(gsw_pkg::out_item_t got);
      gsw_pkg::out_item_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p got %p", exp_r, got);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [6:0] cfg_wdata;
  logic       in_valid;
  logic       in_stall;
  gsw_pkg::in_item_t  in_item;
  logic       out_valid;
  logic       out_stall = 1'b0;
  gsw_pkg::out_item_t out_item;

  walk_scoreboard sb;
  longint unsigned cycles = 0;
  int unsigned stall_mode = 0;

  localparam longint unsigned CycleLimit = 2_000_000;

  graph_store_bfs_dfs_walk_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always #5 clk = ~clk;

  // Accepted items are noted and results checked at the rising edge.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && in_valid && !in_stall) sb.note_item(in_item);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver stall pattern: phases of no stall, light, and heavy stalling.
  always @(negedge clk) begin
    if (($urandom & 255) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Present one item and hold it until accepted.
  task automatic send_item(gsw_pkg::func_e fn, int unsigned f, int unsigned t);
    in_item.func        <= fn;
    in_item.from_vertex <= f[5:0];
    in_item.to_vertex   <= t[5:0];
    in_valid            <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic idle(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Wait out all expected results, then the core's tail latency.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_count(logic [6:0] c);
    drain();
    cfg_wdata <= c;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_count(c);
  endtask

  // Weighted random item: mostly edges within the live range, some walks.
  task automatic random_item(int unsigned span);
    int unsigned r, f, t;
    gsw_pkg::func_e fn;
    r = $urandom_range(0, 99);
    if (r < 55) fn = gsw_pkg::func_e'($urandom_range(0, 1));
    else if (r < 65) fn = gsw_pkg::func_e'($urandom_range(2, 3));
    else if (r < 75) fn = gsw_pkg::FN_QUERY;
    else if (r < 85) fn = gsw_pkg::FN_BFS;
    else if (r < 95) fn = gsw_pkg::FN_DFS;
    else fn = ($urandom_range(0, 3) == 0) ? gsw_pkg::FN_CLEAR : gsw_pkg::FN_QUERY;
    if ($urandom_range(0, 9) == 0) begin
      f = $urandom_range(0, 63);
      t = $urandom_range(0, 63);
    end else begin
      f = $urandom_range(0, span - 1);
      t = $urandom_range(0, span - 1);
    end
    send_item(fn, f, t);
  endtask

  initial begin
    int unsigned burst, span;
    sb = new();
    sb.clear_graph();
    sb.vcount = 64;
    sb.errors = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_item = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, every function, out-of-range, lowered count.
    send_item(gsw_pkg::FN_BFS, 0, 0);            // lone vertex walk
    send_item(gsw_pkg::FN_DFS, 0, 0);
    send_item(gsw_pkg::FN_ADD_DIR, 0, 63);
    send_item(gsw_pkg::FN_ADD_BOTH, 63, 1);
    send_item(gsw_pkg::FN_ADD_DIR, 0, 63);       // repeated add collapses
    send_item(gsw_pkg::FN_ADD_DIR, 1, 2);
    send_item(gsw_pkg::FN_ADD_DIR, 2, 0);
    send_item(gsw_pkg::FN_QUERY, 0, 63);
    send_item(gsw_pkg::FN_QUERY, 63, 0);
    send_item(gsw_pkg::FN_BFS, 0, 0);
    send_item(gsw_pkg::FN_DFS, 0, 0);
    send_item(gsw_pkg::FN_DEL_DIR, 0, 63);
    send_item(gsw_pkg::FN_DEL_BOTH, 1, 63);
    send_item(gsw_pkg::FN_QUERY, 21, 42);
    write_count(7'd3);
    send_item(gsw_pkg::FN_ADD_DIR, 3, 0);        // out of range
    send_item(gsw_pkg::FN_QUERY, 0, 5);
    send_item(gsw_pkg::FN_ADD_BOTH, 0, 1);
    send_item(gsw_pkg::FN_BFS, 0, 0);
    send_item(gsw_pkg::FN_DFS, 0, 0);
    write_count(7'd0);
    send_item(gsw_pkg::FN_BFS, 0, 0);            // no vertices
    send_item(gsw_pkg::FN_QUERY, 0, 0);
    write_count(7'd127);
    send_item(gsw_pkg::FN_CLEAR, 42, 21);
    send_item(gsw_pkg::FN_QUERY, 1, 2);
    // long chain 0..31 for a deep DFS and long walks
    for (int i = 0; i < 31; i++) send_item(gsw_pkg::FN_ADD_DIR, i, i + 1);
    send_item(gsw_pkg::FN_DFS, 0, 0);
    send_item(gsw_pkg::FN_BFS, 0, 0);
    drain();                            // full pause with nothing in flight

    // Random phases at several vertex counts.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_count(7'd64);
        1: write_count(7'd1);
        2: write_count(7'd8);
        3: write_count(7'd100);
        default: write_count(7'($urandom_range(2, 64)));
      endcase
      span = (sb.vcount == 0) ? 1 : ((sb.vcount > 64) ? 64 : sb.vcount);
      if (ph != 1) send_item(gsw_pkg::FN_CLEAR, 0, 0);
      for (int i = 0; i < 8; ) begin
        burst = $urandom_range(1, 8);
        for (int b = 0; b < burst && i < 8; b++, i++) random_item(span);
        if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 12));
      end
    end
    drain();

    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
rtl/gsw_pkg.sv
rtl/graph_store_bfs_dfs_walk_core.sv
bench/graph_store_bfs_dfs_walk_core_tb.sv
